### hw/rtl/servo_bus_packet_transceiver_defines.svh
// Assertion macros shared by the RTL of the servo bus packet transceiver.
// Each macro expects signals named clk and rst_n in the scope of use.
`ifndef SERVO_BUS_PACKET_TRANSCEIVER_DEFINES_SVH
`define SERVO_BUS_PACKET_TRANSCEIVER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SBPT_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SBPT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/sbpt_pkg.sv
package sbpt_pkg;

    localparam logic [1:0] OP_START   = 2'd0;
    localparam logic [1:0] OP_PARAM   = 2'd1;
    localparam logic [1:0] OP_RX      = 2'd2;
    localparam logic [1:0] OP_TIMEOUT = 2'd3;

    localparam logic [1:0] KIND_TX       = 2'd0;
    localparam logic [1:0] KIND_RX_PARAM = 2'd1;
    localparam logic [1:0] KIND_STATUS   = 2'd2;

    localparam logic [3:0] RSN_NONE     = 4'd0;
    localparam logic [3:0] RSN_TOO_MANY = 4'd1;
    localparam logic [3:0] RSN_HEADER   = 4'd2;
    localparam logic [3:0] RSN_ID       = 4'd3;
    localparam logic [3:0] RSN_TYPE     = 4'd4;
    localparam logic [3:0] RSN_SERVO    = 4'd5;
    localparam logic [3:0] RSN_LENGTH   = 4'd6;
    localparam logic [3:0] RSN_CRC      = 4'd7;
    localparam logic [3:0] RSN_TIMEOUT  = 4'd8;

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_TX   = 2'd1;
    localparam logic [1:0] PH_RX   = 2'd2;

    localparam logic [7:0]  STATUS_TYPE = 8'h55;
    localparam logic [7:0]  ERR_MASK    = 8'h7F;
    localparam logic [15:0] CRC_POLY    = 16'h8005;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] dest_id;
        logic [7:0] instruction;
        logic [7:0] param_count;
        logic [7:0] data_byte;
    } item_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] out_byte;
        logic       status;
        logic [3:0] reason;
        logic [7:0] reply_params;
        logic       last;
    } result_t;

    // Packet header FF FF FD 00.
    function automatic logic [7:0] hdr_byte(input logic [1:0] idx);
        logic [7:0] b;
        case (idx)
            2'd0:    b = 8'hFF;
            2'd1:    b = 8'hFF;
            2'd2:    b = 8'hFD;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    // CRC-16, polynomial 0x8005, MSB first, one byte folded in.
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++)
        begin
            if (c[15])
            begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

### hw/rtl/sbpt_in_stage.sv
module sbpt_in_stage
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               valid,
    output logic               stall,
    input  logic [1:0]         op,
    input  logic [7:0]         dest_id,
    input  logic [7:0]         instruction,
    input  logic [7:0]         param_count,
    input  logic [7:0]         data_byte,
    input  logic               release_item,
    output logic               item_valid,
    output sbpt_pkg::item_t    item
);
    import sbpt_pkg::*;

    logic  item_valid_reg;
    item_t item_reg;
    logic  accept;

    // A held item blocks the channel until its final step is taken.
    assign stall  = item_valid_reg & ~release_item;
    assign accept = valid & ~stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            item_valid_reg <= 1'b1;
        end
        else if (release_item)
        begin
            item_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= '{op: op, dest_id: dest_id, instruction: instruction,
                          param_count: param_count, data_byte: data_byte};
        end
    end

    assign item_valid = item_valid_reg;
    assign item       = item_reg;

endmodule

### hw/rtl/sbpt_engine.sv
module sbpt_engine
#(
    parameter int MAX_TX_PARAMS  = 10,
    parameter int RX_FRAME_BYTES = 20
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    input  sbpt_pkg::item_t   item,
    input  logic              advance,
    output logic              item_done,
    output logic              res_load,
    output sbpt_pkg::result_t res
);
    import sbpt_pkg::*;

    localparam logic [7:0]  MAX_CNT     = 8'(MAX_TX_PARAMS);
    localparam logic [16:0] FRAME_LIMIT = 17'(RX_FRAME_BYTES);

    logic [1:0]  phase_reg, phase_next;
    logic [15:0] crc_reg, crc_next;
    logic [7:0]  exp_id_reg, exp_id_next;
    logic [7:0]  tx_left_reg, tx_left_next;
    logic [7:0]  rx_pos_reg, rx_pos_next;
    logic [15:0] rx_len_reg, rx_len_next;
    logic [7:0]  rx_crc_low_reg, rx_crc_low_next;
    logic [3:0]  step_reg, step_next;

    logic        fire;
    logic        step_last;
    logic        emit_crc_lo;
    logic        emit_crc_hi;
    logic        fin;
    logic [3:0]  fin_rsn;
    logic [7:0]  fin_rp;
    logic [8:0]  tx_len;
    logic [7:0]  tx_b;
    logic [16:0] len_ext;
    logic [16:0] pos_ext;
    logic [15:0] rx_got;

    assign fire      = item_valid & advance;
    assign item_done = fire & step_last;

    always_comb
    begin
        phase_next      = phase_reg;
        crc_next        = crc_reg;
        exp_id_next     = exp_id_reg;
        tx_left_next    = tx_left_reg;
        rx_pos_next     = rx_pos_reg;
        rx_len_next     = rx_len_reg;
        rx_crc_low_next = rx_crc_low_reg;
        res_load        = 1'b0;
        res             = '0;
        step_last       = 1'b1;
        emit_crc_lo     = 1'b0;
        emit_crc_hi     = 1'b0;
        fin             = 1'b0;
        fin_rsn         = RSN_NONE;
        fin_rp          = 8'd0;
        tx_len          = {1'b0, item.param_count} + 9'd3;
        tx_b            = 8'd0;
        len_ext         = {1'b0, rx_len_reg};
        pos_ext         = {9'd0, rx_pos_reg};
        rx_got          = {item.data_byte, rx_crc_low_reg};

        case (item.op)
            OP_START:
            begin
                if (item.param_count > MAX_CNT)
                begin
                    fin     = 1'b1;
                    fin_rsn = RSN_TOO_MANY;
                end
                else if (step_reg < 4'd8)
                begin
                    case (step_reg[2:0])
                        3'd4:    tx_b = item.dest_id;
                        3'd5:    tx_b = tx_len[7:0];
                        3'd6:    tx_b = {7'd0, tx_len[8]};
                        3'd7:    tx_b = item.instruction;
                        default: tx_b = hdr_byte(step_reg[1:0]);
                    endcase
                    res_load     = 1'b1;
                    res.kind     = KIND_TX;
                    res.out_byte = tx_b;
                    // The CRC restarts with the first header byte.
                    crc_next = crc_byte((step_reg == 4'd0) ? 16'd0 : crc_reg, tx_b);
                    if (step_reg == 4'd0)
                    begin
                        exp_id_next  = item.dest_id;
                        tx_left_next = item.param_count;
                    end
                    if (step_reg == 4'd7 && item.param_count != 8'd0)
                    begin
                        phase_next = PH_TX;
                    end
                    else
                    begin
                        step_last = 1'b0;
                    end
                end
                else if (step_reg == 4'd8)
                begin
                    emit_crc_lo = 1'b1;
                end
                else
                begin
                    emit_crc_hi = 1'b1;
                end
            end
            OP_PARAM:
            begin
                if (phase_reg == PH_TX)
                begin
                    if (step_reg == 4'd0)
                    begin
                        res_load     = 1'b1;
                        res.kind     = KIND_TX;
                        res.out_byte = item.data_byte;
                        crc_next     = crc_byte(crc_reg, item.data_byte);
                        tx_left_next = tx_left_reg - 8'd1;
                        step_last    = (tx_left_reg != 8'd1);
                    end
                    else if (step_reg == 4'd1)
                    begin
                        emit_crc_lo = 1'b1;
                    end
                    else
                    begin
                        emit_crc_hi = 1'b1;
                    end
                end
            end
            OP_RX:
            begin
                if (phase_reg == PH_RX)
                begin
                    if (rx_pos_reg < 8'd4)
                    begin
                        if (item.data_byte != hdr_byte(rx_pos_reg[1:0]))
                        begin
                            fin     = 1'b1;
                            fin_rsn = RSN_HEADER;
                        end
                    end
                    else if (rx_pos_reg == 8'd4)
                    begin
                        if (item.data_byte != exp_id_reg)
                        begin
                            fin     = 1'b1;
                            fin_rsn = RSN_ID;
                        end
                    end
                    else if (rx_pos_reg == 8'd5)
                    begin
                        rx_len_next = {8'd0, item.data_byte};
                    end
                    else if (rx_pos_reg == 8'd6)
                    begin
                        rx_len_next = {item.data_byte, rx_len_reg[7:0]};
                    end
                    else if (rx_pos_reg == 8'd7)
                    begin
                        if (item.data_byte != STATUS_TYPE)
                        begin
                            fin     = 1'b1;
                            fin_rsn = RSN_TYPE;
                        end
                    end
                    else if (rx_pos_reg == 8'd8)
                    begin
                        // Bit 7 of the error byte is the alert flag and is ignored.
                        if ((item.data_byte & ERR_MASK) != 8'd0)
                        begin
                            fin     = 1'b1;
                            fin_rsn = RSN_SERVO;
                        end
                        else if (rx_len_reg < 16'd4 || len_ext + 17'd7 > FRAME_LIMIT)
                        begin
                            fin     = 1'b1;
                            fin_rsn = RSN_LENGTH;
                        end
                    end
                    else if (pos_ext <= len_ext + 17'd4)
                    begin
                        res_load     = 1'b1;
                        res.kind     = KIND_RX_PARAM;
                        res.out_byte = item.data_byte;
                    end
                    else if (pos_ext == len_ext + 17'd5)
                    begin
                        rx_crc_low_next = item.data_byte;
                    end
                    else
                    begin
                        fin = 1'b1;
                        if (rx_got != crc_reg)
                        begin
                            fin_rsn = RSN_CRC;
                        end
                        else
                        begin
                            fin_rp = rx_len_reg[7:0] - 8'd4;
                        end
                    end

                    // Every byte up to the CRC itself advances the position;
                    // all but the CRC low byte also go into the CRC.
                    if (!fin)
                    begin
                        rx_pos_next = rx_pos_reg + 8'd1;
                        if (!(rx_pos_reg > 8'd8 && pos_ext == len_ext + 17'd5))
                        begin
                            crc_next = crc_byte(crc_reg, item.data_byte);
                        end
                    end
                end
            end
            default:
            begin
                if (phase_reg != PH_IDLE)
                begin
                    fin     = 1'b1;
                    fin_rsn = RSN_TIMEOUT;
                end
            end
        endcase

        if (emit_crc_lo)
        begin
            res_load     = 1'b1;
            res.kind     = KIND_TX;
            res.out_byte = crc_reg[7:0];
            step_last    = 1'b0;
        end

        if (emit_crc_hi)
        begin
            res_load        = 1'b1;
            res.kind        = KIND_TX;
            res.out_byte    = crc_reg[15:8];
            phase_next      = PH_RX;
            crc_next        = 16'd0;
            rx_pos_next     = 8'd0;
            rx_len_next     = 16'd0;
            rx_crc_low_next = 8'd0;
        end

        if (fin)
        begin
            res_load         = 1'b1;
            res.kind         = KIND_STATUS;
            res.status       = (fin_rsn != RSN_NONE);
            res.reason       = fin_rsn;
            res.reply_params = fin_rp;
            phase_next       = PH_IDLE;
        end

        // The item register keeps its last contents after release, so a
        // result only counts while an item is actually held.
        res_load  = res_load & item_valid;
        res.last  = step_last;
        step_next = step_last ? 4'd0 : step_reg + 4'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            crc_reg        <= 16'd0;
            exp_id_reg     <= 8'd0;
            tx_left_reg    <= 8'd0;
            rx_pos_reg     <= 8'd0;
            rx_len_reg     <= 16'd0;
            rx_crc_low_reg <= 8'd0;
            step_reg       <= 4'd0;
        end
        else if (fire)
        begin
            phase_reg      <= phase_next;
            crc_reg        <= crc_next;
            exp_id_reg     <= exp_id_next;
            tx_left_reg    <= tx_left_next;
            rx_pos_reg     <= rx_pos_next;
            rx_len_reg     <= rx_len_next;
            rx_crc_low_reg <= rx_crc_low_next;
            step_reg       <= step_next;
        end
    end

endmodule

### hw/rtl/sbpt_out_stage.sv
module sbpt_out_stage
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              res_load,
    input  sbpt_pkg::result_t res,
    output logic              advance,
    output logic              valid,
    input  logic              stall,
    output logic [1:0]        kind,
    output logic [7:0]        out_byte,
    output logic              status,
    output logic [3:0]        reason,
    output logic [7:0]        reply_params,
    output logic              last
);
    import sbpt_pkg::*;

    logic    res_valid_reg;
    result_t res_reg;

    // The register can take a new result when it is empty or the current one leaves.
    assign advance = ~res_valid_reg | ~stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            res_valid_reg <= res_load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && res_load)
        begin
            res_reg <= res;
        end
    end

    assign valid        = res_valid_reg;
    assign kind         = res_reg.kind;
    assign out_byte     = res_reg.out_byte;
    assign status       = res_reg.status;
    assign reason       = res_reg.reason;
    assign reply_params = res_reg.reply_params;
    assign last         = res_reg.last;

endmodule

### hw/rtl/servo_bus_packet_transceiver.sv
// Servo bus packet transceiver: frames a protocol-2.0 command packet and
// checks the status packet that comes back.
// Command channel (cmd_valid/cmd_stall): op 0 starts a packet, op 1 gives a
// command parameter byte, op 2 gives a received bus byte, op 3 a timeout.
// Result channel (res_valid/res_stall): one result per transaction, with
// last set on the final result caused by an input item.
// The first result of an item is formed from it and registered. Throughput:
// one result per cycle while res_stall does not hold a result; items that
// give zero or one result are taken every cycle on those terms. A start item
// holds the engine for its header, ID, length and instruction bytes, and for
// the CRC bytes too when it has no parameters; the final parameter item for
// its byte and the CRC bytes. cmd_stall stays high until the last step.
// Reset clears the block to idle with a zero CRC; no packet is in progress.
// While res_stall holds a valid result, the result register keeps it, the
// engine does not advance, and a pending item keeps cmd_stall high.
module servo_bus_packet_transceiver
#(
    parameter int MAX_TX_PARAMS  = 10,
    parameter int RX_FRAME_BYTES = 20
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cmd_valid,
    output logic       cmd_stall,
    input  logic [1:0] op,
    input  logic [7:0] dest_id,
    input  logic [7:0] instruction,
    input  logic [7:0] param_count,
    input  logic [7:0] data_byte,
    output logic       res_valid,
    input  logic       res_stall,
    output logic [1:0] kind,
    output logic [7:0] out_byte,
    output logic       status,
    output logic [3:0] reason,
    output logic [7:0] reply_params,
    output logic       last
);
    import sbpt_pkg::*;

    `include "servo_bus_packet_transceiver_defines.svh"

    logic    item_valid;
    item_t   item;
    logic    item_done;
    logic    advance;
    logic    res_load;
    result_t res;

    sbpt_in_stage u_in_stage
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .valid        (cmd_valid),
        .stall        (cmd_stall),
        .op           (op),
        .dest_id      (dest_id),
        .instruction  (instruction),
        .param_count  (param_count),
        .data_byte    (data_byte),
        .release_item (item_done),
        .item_valid   (item_valid),
        .item         (item)
    );

    sbpt_engine
    #(
        .MAX_TX_PARAMS  (MAX_TX_PARAMS),
        .RX_FRAME_BYTES (RX_FRAME_BYTES)
    )
    u_engine
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .advance    (advance),
        .item_done  (item_done),
        .res_load   (res_load),
        .res        (res)
    );

    sbpt_out_stage u_out_stage
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .res_load     (res_load),
        .res          (res),
        .advance      (advance),
        .valid        (res_valid),
        .stall        (res_stall),
        .kind         (kind),
        .out_byte     (out_byte),
        .status       (status),
        .reason       (reason),
        .reply_params (reply_params),
        .last         (last)
    );

    `SBPT_ASSERT_SAME(a_status_is_last, res_valid && kind == KIND_STATUS, last, "status not last")
    `SBPT_ASSERT_SAME(a_status_matches_reason, res_valid && kind == KIND_STATUS,
                      status == (reason != RSN_NONE), "status flag disagrees with reason")
    `SBPT_ASSERT_SAME(a_reply_count_on_ok, res_valid && reply_params != 8'd0,
                      kind == KIND_STATUS && !status, "reply count outside ok status")
    `SBPT_ASSERT_NEXT(a_stall_holds_item, item_valid && res_valid && res_stall,
                      item_valid && $stable(item), "pending item lost under stall")

endmodule

### sim/servo_link_check_pkg.sv
`timescale 1ns / 100ps
package servo_link_check_pkg;
    import sbpt_pkg::*;

    localparam int TX_PARAM_MAX = 10;
    localparam int RX_FRAME_MAX = 20;

    // Protocol 2.0 CRC-16: one byte folded in, MSB first, no reflection.
    function automatic logic [15:0] crc16_fold(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        int i;
        c = crc ^ {b, 8'h00};
        for (i = 0; i < 8; i++)
        begin
            c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

    class servo_link_scoreboard;
        result_t    pending_q[$];
        logic [1:0] phase;
        logic [15:0] crc;
        logic [7:0] target_id;
        logic [7:0] params_left;
        logic [7:0] rx_pos;
        logic [15:0] rx_len;
        logic [7:0] rx_crc_lo;
        int         mismatches;
        int         results_seen;
        int         reason_hits[16];

        function new();
            phase = PH_IDLE;
            crc = '0;
            target_id = '0;
            params_left = '0;
            rx_pos = '0;
            rx_len = '0;
            rx_crc_lo = '0;
            mismatches = 0;
            results_seen = 0;
            foreach (reason_hits[i])
            begin
                reason_hits[i] = 0;
            end
        endfunction

        function string describe(result_t r);
            return $sformatf("kind=%0d byte=%02h status=%0d reason=%0d params=%0d last=%0d",
                             r.kind, r.out_byte, r.status, r.reason, r.reply_params, r.last);
        endfunction

        function void push_result(logic [1:0] k, logic [7:0] b, logic [3:0] rsn,
                                  logic [7:0] rp);
            result_t r;
            r.kind = k;
            r.out_byte = b;
            r.status = (rsn != RSN_NONE);
            r.reason = rsn;
            r.reply_params = rp;
            r.last = 1'b0;
            pending_q.push_back(r);
        endfunction

        function void send_byte(logic [7:0] b);
            crc = crc16_fold(crc, b);
            push_result(KIND_TX, b, RSN_NONE, 8'h00);
        endfunction

        function void end_exchange(logic [3:0] rsn, logic [7:0] rp);
            push_result(KIND_STATUS, 8'h00, rsn, rp);
            phase = PH_IDLE;
        endfunction

        // The CRC bytes themselves are not folded; the reply check starts fresh.
        function void send_crc();
            push_result(KIND_TX, crc[7:0], RSN_NONE, 8'h00);
            push_result(KIND_TX, crc[15:8], RSN_NONE, 8'h00);
            phase = PH_RX;
            crc = '0;
            rx_pos = '0;
            rx_len = '0;
            rx_crc_lo = '0;
        endfunction

        function void take_reply_byte(logic [7:0] b);
            int p;
            int l;
            logic [7:0] hdr;
            p = rx_pos;
            l = rx_len;
            hdr = (p == 2) ? 8'hFD : ((p == 3) ? 8'h00 : 8'hFF);
            if (p < 4)
            begin
                if (b != hdr)
                begin
                    end_exchange(RSN_HEADER, 8'h00);
                    return;
                end
            end
            else if (p == 4)
            begin
                if (b != target_id)
                begin
                    end_exchange(RSN_ID, 8'h00);
                    return;
                end
            end
            else if (p == 5)
            begin
                rx_len = {8'h00, b};
            end
            else if (p == 6)
            begin
                rx_len = {b, rx_len[7:0]};
            end
            else if (p == 7)
            begin
                if (b != STATUS_TYPE)
                begin
                    end_exchange(RSN_TYPE, 8'h00);
                    return;
                end
            end
            else if (p == 8)
            begin
                // Bit 7 of the error byte is the alert flag and is not an error.
                if ((b & ERR_MASK) != 8'h00)
                begin
                    end_exchange(RSN_SERVO, 8'h00);
                    return;
                end
                if (l < 4 || l + 7 > RX_FRAME_MAX)
                begin
                    end_exchange(RSN_LENGTH, 8'h00);
                    return;
                end
            end
            else if (p <= l + 4)
            begin
                push_result(KIND_RX_PARAM, b, RSN_NONE, 8'h00);
            end
            else if (p == l + 5)
            begin
                rx_crc_lo = b;
                rx_pos = rx_pos + 8'd1;
                return;
            end
            else
            begin
                if ({b, rx_crc_lo} != crc)
                begin
                    end_exchange(RSN_CRC, 8'h00);
                end
                else
                begin
                    end_exchange(RSN_NONE, 8'(l - 4));
                end
                return;
            end
            crc = crc16_fold(crc, b);
            rx_pos = rx_pos + 8'd1;
        endfunction

        // Returns 1 when the command mattered to the block, 0 when it was ignored.
        function bit note_command(logic [1:0] op, logic [7:0] id, logic [7:0] typ,
                                  logic [7:0] cnt, logic [7:0] db);
            int base_n;
            bit live;
            logic [15:0] len;
            base_n = pending_q.size();
            live = (op == OP_START) || (op == OP_PARAM && phase == PH_TX) ||
                   (op == OP_RX && phase == PH_RX) || (op == OP_TIMEOUT && phase != PH_IDLE);
            case (op)
                OP_START:
                begin
                    if (cnt > TX_PARAM_MAX)
                    begin
                        end_exchange(RSN_TOO_MANY, 8'h00);
                    end
                    else
                    begin
                        len = {8'h00, cnt} + 16'd3;
                        crc = '0;
                        target_id = id;
                        send_byte(8'hFF);
                        send_byte(8'hFF);
                        send_byte(8'hFD);
                        send_byte(8'h00);
                        send_byte(id);
                        send_byte(len[7:0]);
                        send_byte(len[15:8]);
                        send_byte(typ);
                        params_left = cnt;
                        if (cnt == 8'd0)
                        begin
                            send_crc();
                        end
                        else
                        begin
                            phase = PH_TX;
                        end
                    end
                end
                OP_PARAM:
                begin
                    if (phase == PH_TX)
                    begin
                        send_byte(db);
                        params_left = params_left - 8'd1;
                        if (params_left == 8'd0)
                        begin
                            send_crc();
                        end
                    end
                end
                OP_RX:
                begin
                    if (phase == PH_RX)
                    begin
                        take_reply_byte(db);
                    end
                end
                default:
                begin
                    if (phase != PH_IDLE)
                    begin
                        end_exchange(RSN_TIMEOUT, 8'h00);
                    end
                end
            endcase
            if (pending_q.size() > base_n)
            begin
                pending_q[pending_q.size() - 1].last = 1'b1;
            end
            return live;
        endfunction

        function void check_result(result_t got);
            result_t want;
            results_seen++;
            if (pending_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("unexpected result: %s", describe(got));
                end
                return;
            end
            want = pending_q.pop_front();
            if (want.kind == KIND_STATUS)
            begin
                reason_hits[want.reason]++;
            end
            if (got.kind !== want.kind || got.out_byte !== want.out_byte ||
                got.status !== want.status || got.reason !== want.reason ||
                got.reply_params !== want.reply_params || got.last !== want.last)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("result %0d mismatch", results_seen);
                    $display("  expected %s", describe(want));
                    $display("  actual   %s", describe(got));
                end
            end
        endfunction
    endclass

endpackage

### sim/tb.sv
`timescale 1ns / 100ps
module tb;
    import sbpt_pkg::*;
    import servo_link_check_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam int HOLD_CYCLES = 300;
    localparam int ITEM_TARGET = 320;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cmd_valid = 1'b0;
    logic       cmd_stall;
    logic [1:0] op = OP_START;
    logic [7:0] dest_id = 8'h00;
    logic [7:0] instruction = 8'h00;
    logic [7:0] param_count = 8'h00;
    logic [7:0] data_byte = 8'h00;
    logic       res_valid;
    logic       res_stall = 1'b0;
    logic [1:0] kind;
    logic [7:0] out_byte;
    logic       status;
    logic [3:0] reason;
    logic [7:0] reply_params;
    logic       last;

    servo_link_scoreboard sb;
    int sender_gap_pct = 0;
    int receiver_gap_pct = 0;
    int hold_requests = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int live_items = 0;
    int quiet_cycles = 0;
    int exchanges = 0;

    servo_bus_packet_transceiver #(
        .MAX_TX_PARAMS (TX_PARAM_MAX),
        .RX_FRAME_BYTES(RX_FRAME_MAX)
    ) DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd_stall   (cmd_stall),
        .op          (op),
        .dest_id     (dest_id),
        .instruction (instruction),
        .param_count (param_count),
        .data_byte   (data_byte),
        .res_valid   (res_valid),
        .res_stall   (res_stall),
        .kind        (kind),
        .out_byte    (out_byte),
        .status      (status),
        .reason      (reason),
        .reply_params(reply_params),
        .last        (last)
    );

    always #1 clk = ~clk;

    // Result side back-pressure; a hold request stalls it for a long stretch.
    always @(posedge clk)
    begin
        if (hold_requests != hold_seen)
        begin
            hold_seen = hold_requests;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            res_stall <= 1'b1;
        end
        else
        begin
            res_stall <= ($urandom_range(0, 99) < receiver_gap_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (res_valid && !res_stall)
            begin
                sb.check_result({kind, out_byte, status, reason, reply_params, last});
            end
            if (cmd_valid && !cmd_stall)
            begin
                if (sb.note_command(op, dest_id, instruction, param_count, data_byte))
                begin
                    live_items++;
                end
            end
            if ((res_valid && !res_stall) || (cmd_valid && !cmd_stall))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
            end
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("no transaction for %0d cycles, %0d results outstanding",
                         quiet_cycles, sb.pending_q.size());
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    function automatic logic [7:0] any_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic send_item(input logic [1:0] o, input logic [7:0] id, input logic [7:0] typ,
                             input logic [7:0] cnt, input logic [7:0] db);
        while ($urandom_range(0, 99) < sender_gap_pct)
        begin
            cmd_valid <= 1'b0;
            @(posedge clk);
        end
        cmd_valid <= 1'b1;
        op <= o;
        dest_id <= id;
        instruction <= typ;
        param_count <= cnt;
        data_byte <= db;
        @(posedge clk);
        while (cmd_stall !== 1'b0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic send_noise(input logic [1:0] o, input logic [7:0] db);
        send_item(o, any_byte(), any_byte(), any_byte(), db);
    endtask

    task automatic wait_drained();
        cmd_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending_q.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // One command packet and its status reply. Most replies are well formed;
    // the rest carry one flaw, get cut short, or are aborted by a new start.
    task automatic run_exchange();
        logic [7:0]  id;
        logic [7:0]  typ;
        logic [7:0]  cnt;
        logic [7:0]  mask;
        logic [7:0]  frame[$];
        logic [15:0] crc;
        logic [15:0] len;
        int          flaw;
        int          stop_at;
        int          k;
        int          i;
        id = any_byte();
        typ = any_byte();
        mask = 8'($urandom_range(1, 255));
        if ($urandom_range(0, 9) == 0)
        begin
            cnt = 8'($urandom_range(TX_PARAM_MAX + 1, 255));
        end
        else
        begin
            cnt = 8'($urandom_range(0, TX_PARAM_MAX));
        end
        exchanges++;
        send_item(OP_START, id, typ, cnt, any_byte());
        if (cnt > TX_PARAM_MAX)
        begin
            return;
        end
        flaw = $urandom_range(0, 19);
        stop_at = $urandom_range(0, cnt + 11);

        len = 16'($urandom_range(0, RX_FRAME_MAX - 11)) + 16'd4;
        frame = '{8'hFF, 8'hFF, 8'hFD, 8'h00, id, len[7:0], len[15:8], STATUS_TYPE};
        frame.push_back($urandom_range(0, 1) ? 8'h80 : 8'h00);
        for (i = 0; i < len - 4; i++)
        begin
            frame.push_back(any_byte());
        end
        crc = '0;
        foreach (frame[j])
        begin
            crc = crc16_fold(crc, frame[j]);
        end
        frame.push_back(crc[7:0]);
        frame.push_back(crc[15:8]);

        case (flaw)
            12:
            begin
                k = $urandom_range(0, 3);
                frame[k] = frame[k] ^ mask;
            end
            13: frame[4] = frame[4] ^ mask;
            14: frame[7] = frame[7] ^ mask;
            15: frame[8] = frame[8] | (8'h01 << $urandom_range(0, 6));
            16:
            begin
                k = $urandom_range(0, 2);
                if (k == 0)
                begin
                    len = 16'($urandom_range(0, 3));
                end
                else if (k == 1)
                begin
                    len = 16'(RX_FRAME_MAX - 6);
                end
                else
                begin
                    len = 16'($urandom_range(RX_FRAME_MAX - 6, 65535));
                end
                frame[5] = len[7:0];
                frame[6] = len[15:8];
            end
            17:
            begin
                k = frame.size() - 1 - $urandom_range(0, 1);
                frame[k] = frame[k] ^ mask;
            end
            default:
            begin
            end
        endcase

        for (i = 0; i < cnt + frame.size(); i++)
        begin
            if (flaw >= 18 && i == stop_at)
            begin
                if (flaw == 18)
                begin
                    send_noise(OP_TIMEOUT, any_byte());
                end
                else
                begin
                    send_item(OP_START, any_byte(), any_byte(),
                              8'($urandom_range(0, TX_PARAM_MAX)), any_byte());
                end
                return;
            end
            if (i < cnt)
            begin
                send_noise(OP_PARAM, any_byte());
            end
            else
            begin
                // A parameter byte during the reply is ignored by the block.
                if ($urandom_range(0, 9) == 0)
                begin
                    send_noise(OP_PARAM, any_byte());
                end
                send_noise(OP_RX, frame[i - cnt]);
            end
        end
    endtask

    initial
    begin
        int goal;
        bit held;
        sb = new();
        held = 1'b0;
        sender_gap_pct = 15;
        receiver_gap_pct <= 61;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: ignored commands, parameter count limits, timeouts in both
        // directions, restart while busy and a header error.
        send_item(OP_PARAM, 8'h00, 8'h00, 8'h00, 8'hFF);
        send_item(OP_RX, 8'hFF, 8'hFF, 8'hFF, 8'h00);
        send_item(OP_TIMEOUT, 8'hFF, 8'h00, 8'hFF, 8'hFF);
        send_item(OP_START, 8'h01, 8'h03, 8'hFF, 8'h00);
        send_item(OP_START, 8'h01, 8'h03, 8'(TX_PARAM_MAX + 1), 8'h00);
        send_item(OP_START, 8'hFF, 8'hFF, 8'h00, 8'h00);
        send_item(OP_PARAM, 8'h00, 8'h00, 8'h00, 8'h5A);
        send_item(OP_TIMEOUT, 8'h00, 8'h00, 8'h00, 8'h00);
        send_item(OP_START, 8'h00, 8'h00, 8'(TX_PARAM_MAX), 8'hFF);
        send_item(OP_RX, 8'h00, 8'h00, 8'h00, 8'hFF);
        send_item(OP_TIMEOUT, 8'h00, 8'h00, 8'h00, 8'h00);
        send_item(OP_START, 8'h07, 8'h02, 8'h01, 8'h00);
        send_item(OP_START, 8'h07, 8'h02, 8'h00, 8'h00);
        send_item(OP_RX, 8'h00, 8'h00, 8'h00, 8'hFF);
        send_item(OP_RX, 8'h00, 8'h00, 8'h00, 8'hFF);
        send_item(OP_RX, 8'h00, 8'h00, 8'h00, 8'hFD);
        send_item(OP_RX, 8'h00, 8'h00, 8'h00, 8'h01);
        send_item(OP_START, 8'h80, 8'h03, 8'h01, 8'h00);
        send_item(OP_PARAM, 8'h00, 8'h00, 8'h00, 8'hA5);
        send_item(OP_START, 8'h80, 8'h03, 8'h00, 8'h00);
        wait_drained();

        // Sender mostly busy, receiver often stalled, with one long hold-off.
        goal = live_items + ITEM_TARGET / 3;
        while (live_items < goal)
        begin
            if (!held && live_items >= goal - ITEM_TARGET / 6)
            begin
                hold_requests <= hold_requests + 1;
                held = 1'b1;
            end
            run_exchange();
        end
        wait_drained();

        sender_gap_pct = 61;
        receiver_gap_pct <= 15;
        goal = live_items + ITEM_TARGET / 3;
        while (live_items < goal)
        begin
            run_exchange();
        end
        wait_drained();

        sender_gap_pct = 0;
        receiver_gap_pct <= 0;
        goal = live_items + ITEM_TARGET / 3;
        while (live_items < goal)
        begin
            run_exchange();
        end
        wait_drained();
        repeat (20) @(posedge clk);

        if (sb.pending_q.size() != 0)
        begin
            $display("%0d expected results never arrived", sb.pending_q.size());
            sb.mismatches += sb.pending_q.size();
        end
        $display("Ran %0d exchanges (%0d effective commands), checked %0d results, %0d bad.",
                 exchanges, live_items, sb.results_seen, sb.mismatches);
        $display("Statuses by reason, none through timeout: %0d %0d %0d %0d %0d %0d %0d %0d %0d",
                 sb.reason_hits[0], sb.reason_hits[1], sb.reason_hits[2], sb.reason_hits[3],
                 sb.reason_hits[4], sb.reason_hits[5], sb.reason_hits[6], sb.reason_hits[7],
                 sb.reason_hits[8]);
        if (sb.mismatches == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

### files.f
+incdir+hw/rtl
hw/rtl/sbpt_pkg.sv
hw/rtl/sbpt_in_stage.sv
hw/rtl/sbpt_engine.sv
hw/rtl/sbpt_out_stage.sv
hw/rtl/servo_bus_packet_transceiver.sv
sim/servo_link_check_pkg.sv
sim/tb.sv
